// ----- rtl/csg_pkg.sv -----
`default_nettype none
package csg_pkg;
	localparam int unsigned MAX_CHOOSE = 8;
	localparam int unsigned MAX_SET = 32;
	localparam int unsigned POS_W = 6;
	localparam int unsigned RANK_W = 24;
	localparam logic [RANK_W-1:0] RANK_SAT = {RANK_W{1'b1}};

	typedef enum logic [1:0] {
		ACT_RESTART = 2'd0,
		ACT_ADVANCE = 2'd1,
		ACT_JUMP    = 2'd2,
		ACT_READ    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_RANK_OOR = 2'd1,
		ST_R_GT_N   = 2'd2
	} status_t;

	localparam logic CFG_SET_SIZE = 1'b0;
	localparam logic CFG_CHOOSE_SIZE = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic restart;     // load the first combination
		logic binom_start; // begin C(bn, bk) computation
		logic binom_total; // operands are (n, r) rather than the unrank pair
		logic adv_step;    // one step of the advance carry walk
		logic adv_init;    // begin the advance walk at the last position
		logic unr_init;    // begin unranking
		logic unr_step;    // evaluate one candidate with the ready coefficient
		logic unr_fin;     // write the last position from the remaining rank
		logic load_total;  // capture the finished coefficient as the total
	} csg_cmd_t;

	typedef struct packed {
		logic binom_done;
		logic adv_done;
		logic unr_done;
		logic r_gt_n;
		logic r_zero;
		logic is_done;
		logic rank_oor;
	} csg_stat_t;
endpackage
`default_nettype wire

// ----- rtl/combination_sequence_generator_unit.sv -----
// Lexicographic r-combination generator with unranking.
// Channels: cfg (cfg_valid/cfg_ready, cfg_index, cfg_data) writes set_size
// (index 0) or choose_size (index 1); either write restarts the sequence.
// cfg_ready is high only while no transaction is in flight.
// Input transaction: action and target_rank on in_valid/in_ready.
// Output transaction: elem_0..elem_7, finished, total_combinations, status on
// out_valid/out_ready. One item is in flight at a time; after the result is
// taken the block returns to idle, where it can accept the next input.
// Processing order: the total C(n,r) comes first from a shared binomial unit
// (which skips its multiply and divide steps when r is 0 or exceeds n), plus
// a launch and a dispatch state; restart and read end with these.
// Advance adds the carry walk over w positions, at most r of them. A jump
// adds a closing step plus, per candidate value, a binomial computation
// with k = r-1-i for position i; there are at most n-1 candidates.
// Reset: n = r = 0 and the empty combination is current.
// While the receiver stalls, the result is held and no new input is taken.
`default_nettype none
module combination_sequence_generator_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [5:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  action,
	input  wire logic [23:0] target_rank,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [5:0]       elem_0,
	output logic [5:0]       elem_1,
	output logic [5:0]       elem_2,
	output logic [5:0]       elem_3,
	output logic [5:0]       elem_4,
	output logic [5:0]       elem_5,
	output logic [5:0]       elem_6,
	output logic [5:0]       elem_7,
	output logic             finished,
	output logic [23:0]      total_combinations,
	output logic [1:0]       status
);
	import csg_pkg::*;

	logic [5:0] set_size_q;
	logic [3:0] choose_size_q;
	logic [23:0] rank_q;
	csg_cmd_t cmd;
	csg_stat_t stat;
	logic cap;
	logic [1:0] st;
	logic [POS_W-1:0] pos [MAX_CHOOSE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_size_q <= '0;
			choose_size_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_SET_SIZE)
				set_size_q <= (cfg_data > 6'(MAX_SET)) ? 6'(MAX_SET) : cfg_data;
			else
				choose_size_q <= (cfg_data[3:0] > 4'(MAX_CHOOSE)) ? 4'(MAX_CHOOSE) :
					cfg_data[3:0];
		end
	end

	always_ff @(posedge clk) if (in_valid && in_ready) rank_q <= target_rank;

	csg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.action(action), .out_valid(out_valid), .out_ready(out_ready),
		.cfg_write(cfg_valid), .cfg_ready(cfg_ready), .cmd(cmd), .stat(stat),
		.cap(cap), .status(st)
	);

	csg_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.set_size(set_size_q), .choose_size(choose_size_q), .rank_in(rank_q),
		.pos_out(pos), .total_out(total_combinations)
	);

	logic r_bad;
	assign r_bad = (st == ST_R_GT_N) || cap;
	assign elem_0 = r_bad ? '0 : pos[0];
	assign elem_1 = r_bad ? '0 : pos[1];
	assign elem_2 = r_bad ? '0 : pos[2];
	assign elem_3 = r_bad ? '0 : pos[3];
	assign elem_4 = r_bad ? '0 : pos[4];
	assign elem_5 = r_bad ? '0 : pos[5];
	assign elem_6 = r_bad ? '0 : pos[6];
	assign elem_7 = r_bad ? '0 : pos[7];
	assign finished = r_bad ? 1'b0 : stat.is_done;
	assign status = st;
endmodule
`default_nettype wire

// ----- rtl/csg_datapath.sv -----
`default_nettype none
module csg_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire csg_pkg::csg_cmd_t             cmd,
	output csg_pkg::csg_stat_t                 stat,
	input  wire logic [5:0]                    set_size,
	input  wire logic [3:0]                    choose_size,
	input  wire logic [csg_pkg::RANK_W-1:0]    rank_in,
	output logic [csg_pkg::POS_W-1:0]          pos_out [csg_pkg::MAX_CHOOSE],
	output logic [csg_pkg::RANK_W-1:0]         total_out
);
	import csg_pkg::*;

	localparam int unsigned IDX_W = (MAX_CHOOSE > 1) ? $clog2(MAX_CHOOSE) : 1;
	localparam int unsigned CW = RANK_W + 1;   // coefficient with saturation headroom
	localparam int unsigned PW = CW + POS_W;    // product width

	logic [POS_W-1:0] pos_q [MAX_CHOOSE];
	logic [POS_W-1:0] n_v, r_v;

	assign n_v = set_size;
	assign r_v = {2'b00, choose_size};

	// Binomial unit: per factor a multiply step, then a divide of the PW-bit product.
	// c <- c*(bn-i)/(i+1); the divide is iterative, bit-serial.
	typedef enum logic [1:0] {B_IDLE, B_MUL, B_DIV, B_DONE} bst_t;
	bst_t bst_q;
	logic [POS_W-1:0] bn_q, bk_q, bi_q;
	logic [CW-1:0] c_q;
	logic [PW-1:0] prod_q, quo_q;
	logic [POS_W:0] rem_q;
	logic [POS_W-1:0] dcnt_q;
	logic [POS_W-1:0] div_v;
	logic [POS_W:0] rem_sh;

	assign div_v = bi_q + POS_W'(1);
	assign rem_sh = {rem_q[POS_W-1:0], prod_q[PW-1]};

	// Unrank state.
	logic [IDX_W:0] ui_q;
	logic [POS_W-1:0] uj_q, lo_q;
	logic [RANK_W-1:0] rem_rank_q;
	logic [CW-1:0] total_q;
	logic [IDX_W:0] ai_q;

	logic [POS_W-1:0] unr_n, unr_k;
	assign unr_n = n_v - POS_W'(1) - uj_q;
	assign unr_k = r_v - POS_W'(1) - POS_W'(ui_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bst_q <= B_IDLE;
		end else begin
			case (bst_q)
				B_IDLE: if (cmd.binom_start) bst_q <= (cmd.binom_total ? r_v : unr_k) == '0 ||
					(cmd.binom_total ? r_v > n_v : unr_k > unr_n) ? B_DONE : B_MUL;
				B_MUL: bst_q <= (bi_q == bk_q) ? B_DONE : B_DIV;
				B_DIV: if (dcnt_q == POS_W'(PW - 1)) bst_q <= B_MUL;
				B_DONE: bst_q <= B_IDLE;
				default: bst_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (bst_q)
			B_IDLE: if (cmd.binom_start) begin
				bn_q <= cmd.binom_total ? n_v : unr_n;
				bk_q <= cmd.binom_total ? r_v : unr_k;
				bi_q <= '0;
				c_q <= ((cmd.binom_total ? r_v > n_v : unr_k > unr_n)) ? CW'(0) : CW'(1);
			end
			B_MUL: begin
				prod_q <= PW'(c_q) * PW'(bn_q - bi_q);
				rem_q <= '0;
				dcnt_q <= '0;
			end
			B_DIV: begin
				dcnt_q <= dcnt_q + POS_W'(1);
				prod_q <= {prod_q[PW-2:0], 1'b0};
				if (rem_sh >= {1'b0, div_v}) begin
					rem_q <= rem_sh - {1'b0, div_v};
					quo_q <= {quo_q[PW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[PW-2:0], 1'b0};
				end
				if (dcnt_q == POS_W'(PW - 1)) begin
					bi_q <= bi_q + POS_W'(1);
					// Saturated values only need to stay above every rank.
					if (rem_sh >= {1'b0, div_v}) begin
						if ({quo_q[PW-2:0], 1'b1} > PW'({1'b0, RANK_SAT})) begin
							c_q <= {1'b1, RANK_SAT};
						end else c_q <= CW'({quo_q[PW-2:0], 1'b1});
					end else begin
						if ({quo_q[PW-2:0], 1'b0} > PW'({1'b0, RANK_SAT})) begin
							c_q <= {1'b1, RANK_SAT};
						end else c_q <= CW'({quo_q[PW-2:0], 1'b0});
					end
				end
			end
			default: ;
		endcase
	end

	assign stat.binom_done = (bst_q == B_DONE);

	// Unranking: candidate j for position i, coefficient from the binomial unit.
	logic unr_last;
	logic unr_hit;
	assign unr_last = (ui_q + (IDX_W+1)'(1) >= (IDX_W+1)'(r_v));
	assign unr_hit = (c_q[RANK_W] == 1'b0 && rem_rank_q < c_q[RANK_W-1:0]) || c_q[RANK_W];

	// Advance walk.
	logic [POS_W-1:0] adv_inc, adv_lim;
	logic [IDX_W-1:0] ai_idx;
	logic adv_walk_q;
	assign ai_idx = ai_q[IDX_W-1:0] - IDX_W'(1);
	assign adv_inc = pos_q[ai_idx] + POS_W'(1);
	assign adv_lim = n_v - (r_v - POS_W'(ai_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_CHOOSE; k++) pos_q[k] <= POS_W'(k);
			adv_walk_q <= 1'b0;
		end else begin
			if (cmd.restart) begin
				for (int k = 0; k < MAX_CHOOSE; k++) pos_q[k] <= POS_W'(k);
				if (choose_size == '0) pos_q[0] <= '0;
			end else if (cmd.adv_init) begin
				if (choose_size == '0) pos_q[0] <= POS_W'(1);
				adv_walk_q <= (choose_size != '0);
			end else if (cmd.adv_step && adv_walk_q) begin
				pos_q[ai_idx] <= adv_inc;
				if (adv_inc != adv_lim || ai_q == (IDX_W+1)'(1)) begin
					adv_walk_q <= 1'b0;
					if (adv_inc != adv_lim)
						for (int k = 0; k < MAX_CHOOSE; k++)
							if ((IDX_W+1)'(k) >= ai_q && POS_W'(k) < r_v)
								pos_q[k] <= adv_inc + POS_W'(k) - POS_W'(ai_idx);
				end
			end else if (cmd.unr_init && choose_size == '0) begin
				pos_q[0] <= '0;
			end else if (cmd.unr_step) begin
				if (unr_hit || uj_q >= n_v - r_v + POS_W'(ui_q)) begin
					pos_q[ui_q[IDX_W-1:0]] <= uj_q;
				end
			end else if (cmd.unr_fin) begin
				pos_q[ui_q[IDX_W-1:0]] <= lo_q + POS_W'(rem_rank_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.adv_init) ai_q <= (IDX_W+1)'(choose_size);
		else if (cmd.adv_step && adv_walk_q) ai_q <= ai_q - (IDX_W+1)'(1);
	end

	assign stat.adv_done = !adv_walk_q;

	always_ff @(posedge clk) begin
		if (cmd.unr_init) begin
			ui_q <= '0;
			uj_q <= '0;
			lo_q <= '0;
			rem_rank_q <= rank_in;
		end else if (cmd.unr_step) begin
			if (uj_q >= n_v - r_v + POS_W'(ui_q) || unr_hit) begin
				lo_q <= uj_q + POS_W'(1);
				uj_q <= uj_q + POS_W'(1);
				ui_q <= ui_q + (IDX_W+1)'(1);
			end else begin
				rem_rank_q <= rem_rank_q - c_q[RANK_W-1:0];
				uj_q <= uj_q + POS_W'(1);
			end
		end
		if (cmd.load_total) total_q <= c_q;
	end

	assign stat.unr_done = unr_last;
	assign stat.r_gt_n = r_v > n_v;
	assign stat.r_zero = (choose_size == '0);
	assign stat.is_done = (choose_size == '0) ? (pos_q[0] == POS_W'(1)) :
		(pos_q[IDX_W'(r_v - POS_W'(1))] == n_v);
	assign stat.rank_oor = (total_q[RANK_W] == 1'b0) && (rank_in >= total_q[RANK_W-1:0]);

	always_comb begin
		for (int k = 0; k < MAX_CHOOSE; k++)
			pos_out[k] = (POS_W'(k) < r_v) ? pos_q[k] : '0;
	end
	assign total_out = total_q[RANK_W] ? RANK_SAT : total_q[RANK_W-1:0];
endmodule
`default_nettype wire

// ----- rtl/csg_ctrl.sv -----
`default_nettype none
module csg_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         action,
	output logic                    out_valid,
	input  wire logic               out_ready,
	input  wire logic               cfg_write,
	output logic                    cfg_ready,
	output csg_pkg::csg_cmd_t       cmd,
	input  wire csg_pkg::csg_stat_t stat,
	output logic                    cap,
	output logic [1:0]              status
);
	import csg_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_TOT_GO, S_TOT_WAIT, S_DISPATCH, S_ADV, S_UNR_GO, S_UNR_WAIT,
		S_UNR_STEP, S_UNR_LAST, S_OUT
	} state_t;
	state_t state_q;
	action_t act_q;

	assign cfg_ready = (state_q == S_IDLE);
	assign in_ready = (state_q == S_IDLE) && !cfg_write;
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd = '0;
		cap = 1'b0;
		case (state_q)
			S_IDLE: if (cfg_write) cmd.restart = 1'b1;
			S_TOT_GO: begin
				cmd.binom_start = 1'b1;
				cmd.binom_total = 1'b1;
			end
			S_TOT_WAIT: if (stat.binom_done) cmd.load_total = 1'b1;
			S_DISPATCH: begin
				if (!stat.r_gt_n) begin
					case (act_q)
						ACT_RESTART: cmd.restart = 1'b1;
						ACT_ADVANCE: cmd.adv_init = !stat.is_done;
						ACT_JUMP: cmd.unr_init = !stat.rank_oor;
						default: ;
					endcase
				end
			end
			S_ADV: cmd.adv_step = 1'b1;
			S_UNR_LAST: cmd.unr_fin = stat.unr_done;
			S_UNR_GO: cmd.binom_start = 1'b1;
			S_UNR_WAIT: if (stat.binom_done) cmd.unr_step = 1'b1;
			S_OUT: cap = 1'b0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			act_q <= ACT_READ;
			status <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid && in_ready) begin
					act_q <= action_t'(action);
					state_q <= S_TOT_GO;
				end
				S_TOT_GO: state_q <= S_TOT_WAIT;
				S_TOT_WAIT: if (stat.binom_done) state_q <= S_DISPATCH;
				S_DISPATCH: begin
					status <= ST_OK;
					state_q <= S_OUT;
					if (stat.r_gt_n) status <= ST_R_GT_N;
					else if (act_q == ACT_ADVANCE && !stat.is_done && !stat.r_zero)
						state_q <= S_ADV;
					else if (act_q == ACT_JUMP) begin
						if (stat.rank_oor) status <= ST_RANK_OOR;
						else if (!stat.r_zero) state_q <= S_UNR_LAST;
					end
				end
				S_ADV: if (stat.adv_done) state_q <= S_OUT;
				S_UNR_LAST: state_q <= stat.unr_done ? S_OUT : S_UNR_GO;
				S_UNR_GO: state_q <= S_UNR_WAIT;
				S_UNR_WAIT: if (stat.binom_done) state_q <= S_UNR_STEP;
				S_UNR_STEP: state_q <= S_UNR_LAST;
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/csg_checker.sv -----
`default_nettype none
module csg_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [1:0] status,
	input wire logic finished,
	input wire logic [23:0] total_combinations
);
	import csg_pkg::*;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result dropped under stall");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_R_GT_N) else $error("bad status");
	a_rgtn: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_R_GT_N |-> total_combinations == 24'd0 && !finished)
		else $error("r exceeds n result wrong");
endmodule
bind combination_sequence_generator_unit csg_checker u_csg_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .status(status),
	.finished(finished), .total_combinations(total_combinations)
);
`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
module tb;
	import csg_pkg::*;

	typedef struct {
		logic [5:0]  elem [8];
		logic        finished;
		logic [23:0] total;
		status_t     status;
	} combo_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [5:0]  cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  action = '0;
	logic [23:0] target_rank = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [5:0]  elem_0, elem_1, elem_2, elem_3, elem_4, elem_5, elem_6, elem_7;
	logic        finished;
	logic [23:0] total_combinations;
	logic [1:0]  status;

	// Shadow copy of the block's state.
	int unsigned   n_elems;
	int unsigned   r_elems;
	int unsigned   combo_pos [8];
	combo_result_t pending_results [$];
	int            fail_count = 0;
	int            send_idle_pct = 0;
	int            recv_stall_pct = 0;

	combination_sequence_generator_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .action(action),
		.target_rank(target_rank),
		.out_valid(out_valid), .out_ready(out_ready),
		.elem_0(elem_0), .elem_1(elem_1), .elem_2(elem_2), .elem_3(elem_3),
		.elem_4(elem_4), .elem_5(elem_5), .elem_6(elem_6), .elem_7(elem_7),
		.finished(finished), .total_combinations(total_combinations), .status(status)
	);

	always #6 clk = ~clk;

	function automatic longint unsigned choose_count(int unsigned n, int unsigned k);
		longint unsigned c;
		c = 1;
		if (k > n)
			return 0;
		for (int unsigned i = 0; i < k; i++)
			c = c * (n - i) / (i + 1);
		return c;
	endfunction

	function automatic void restart_combo();
		for (int k = 0; k < 8; k++)
			combo_pos[k] = k;
		if (r_elems == 0)
			combo_pos[0] = 0;
	endfunction

	function automatic bit combo_exhausted();
		if (r_elems == 0)
			return combo_pos[0] == 1;
		return combo_pos[r_elems-1] == n_elems;
	endfunction

	function automatic void next_combo();
		int unsigned idx;
		if (combo_exhausted())
			return;
		if (r_elems == 0) begin
			combo_pos[0] = 1;
			return;
		end
		for (int unsigned i = r_elems; i > 0; i--) begin
			idx = i - 1;
			combo_pos[idx] += 1;
			if (combo_pos[idx] + (r_elems - i) != n_elems) begin
				for (int unsigned j = idx + 1; j < r_elems; j++)
					combo_pos[j] = combo_pos[j-1] + 1;
				return;
			end
		end
	endfunction

	function automatic void unrank_combo(longint unsigned rank);
		longint unsigned rem, c;
		int unsigned lo, j;
		rem = rank;
		lo = 0;
		if (r_elems == 0) begin
			combo_pos[0] = 0;
			return;
		end
		for (int unsigned i = 0; i + 1 < r_elems; i++) begin
			for (j = lo; j < n_elems - r_elems + i; j++) begin
				c = choose_count(n_elems - 1 - j, r_elems - 1 - i);
				if (rem < c)
					break;
				rem -= c;
			end
			combo_pos[i] = j;
			lo = j + 1;
		end
		combo_pos[r_elems-1] = lo + int'(rem);
	endfunction

	function automatic combo_result_t predict_combo(action_t act, logic [23:0] rank);
		combo_result_t res;
		longint unsigned total;
		for (int k = 0; k < 8; k++)
			res.elem[k] = '0;
		res.finished = 1'b0;
		res.total = '0;
		res.status = ST_OK;
		if (r_elems > n_elems) begin
			res.status = ST_R_GT_N;
			return res;
		end
		total = choose_count(n_elems, r_elems);
		case (act)
			ACT_RESTART: restart_combo();
			ACT_ADVANCE: next_combo();
			ACT_JUMP: begin
				if (rank >= total)
					res.status = ST_RANK_OOR;
				else
					unrank_combo(rank);
			end
			default: ;
		endcase
		for (int k = 0; k < 8; k++)
			if (k < r_elems)
				res.elem[k] = combo_pos[k][5:0];
		res.finished = combo_exhausted();
		res.total = total > 64'hFFFFFF ? 24'hFFFFFF : total[23:0];
		return res;
	endfunction

	// Receiver: stalls at random, sampled by the checker at the rising edge.
	always @(negedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

	always @(posedge clk) begin
		combo_result_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got.elem[0] = elem_0; got.elem[1] = elem_1; got.elem[2] = elem_2;
			got.elem[3] = elem_3; got.elem[4] = elem_4; got.elem[5] = elem_5;
			got.elem[6] = elem_6; got.elem[7] = elem_7;
			got.finished = finished;
			got.total = total_combinations;
			got.status = status_t'(status);
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result transaction", $time);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				for (int k = 0; k < 8; k++)
					if (got.elem[k] !== want.elem[k]) begin
						$display("%0t: elem_%0d expected %0d actual %0d", $time, k,
							want.elem[k], got.elem[k]);
						fail_count++;
					end
				if (got.finished !== want.finished) begin
					$display("%0t: finished expected %0b actual %0b", $time,
						want.finished, got.finished);
					fail_count++;
				end
				if (got.total !== want.total) begin
					$display("%0t: total_combinations expected %0d actual %0d", $time,
						want.total, got.total);
					fail_count++;
				end
				if (got.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						want.status, got.status);
					fail_count++;
				end
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance
	// with valid still high, so back-to-back transactions need no gap.
	task automatic send_item(action_t act, logic [23:0] rank);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		target_rank <= rank;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(predict_combo(act, rank));
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [5:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_SET_SIZE)
			n_elems = value > 32 ? 32 : value;
		else
			r_elems = value[3:0] > 8 ? 8 : value[3:0];
		restart_combo();
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_shape(logic [5:0] n, logic [5:0] r);
		write_reg(CFG_SET_SIZE, n);
		write_reg(CFG_CHOOSE_SIZE, r);
	endtask

	function automatic logic [23:0] rank_in_range();
		longint unsigned total;
		total = choose_count(n_elems, r_elems);
		if (total == 0)
			return 24'd0;
		return 24'($urandom_range(0, int'(total - 1)));
	endfunction

	task automatic test_after_reset();
		send_item(ACT_READ, 24'd0);
		send_item(ACT_ADVANCE, 24'd0);
		send_item(ACT_ADVANCE, 24'd0);
		send_item(ACT_JUMP, 24'd0);
		send_item(ACT_JUMP, 24'd1);
		send_item(ACT_RESTART, 24'hFFFFFF);
	endtask

	task automatic test_extremes();
		// Data above the limits saturates: 63 gives 32 and 15 gives 8.
		set_shape(6'd63, 6'd15);
		send_item(ACT_READ, 24'd0);
		send_item(ACT_JUMP, 24'd0);
		send_item(ACT_JUMP, 24'd10518299);
		send_item(ACT_ADVANCE, 24'd0);
		send_item(ACT_JUMP, 24'd10518300);
		send_item(ACT_JUMP, 24'hFFFFFF);
		send_item(ACT_RESTART, 24'd0);
		// Choose size above the set size refuses every action.
		set_shape(6'd3, 6'd5);
		send_item(ACT_RESTART, 24'd0);
		send_item(ACT_ADVANCE, 24'd0);
		send_item(ACT_JUMP, 24'd0);
		send_item(ACT_READ, 24'd0);
		// Walk off the end of a single combination and keep advancing.
		set_shape(6'd4, 6'd4);
		send_item(ACT_ADVANCE, 24'd0);
		send_item(ACT_ADVANCE, 24'd0);
		send_item(ACT_JUMP, 24'd0);
		set_shape(6'd0, 6'd0);
		send_item(ACT_ADVANCE, 24'd0);
		send_item(ACT_JUMP, 24'd0);
	endtask

	task automatic test_random_walks(int items);
		int sent;
		int pick;
		logic [5:0] n, r;
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(0, 99) < 12)
				n = $urandom_range(13, 32);
			else
				n = $urandom_range(0, 12);
			r = $urandom_range(0, 9);
			if ($urandom_range(0, 9) == 0)
				r = $urandom_range(0, 63);
			set_shape(n, r);
			send_item(ACT_RESTART, 24'($urandom()));
			sent++;
			repeat ($urandom_range(10, 40)) begin
				pick = $urandom_range(0, 99);
				if (pick < 55)
					send_item(ACT_ADVANCE, 24'($urandom()));
				else if (pick < 75)
					send_item(ACT_JUMP, rank_in_range());
				else if (pick < 80)
					send_item(ACT_JUMP, 24'($urandom()));
				else if (pick < 90)
					send_item(ACT_READ, 24'($urandom()));
				else
					send_item(ACT_RESTART, 24'($urandom()));
				sent++;
			end
		end
	endtask

	initial begin
		n_elems = 0;
		r_elems = 0;
		restart_combo();
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_after_reset();
		test_extremes();
		send_idle_pct = 0;  recv_stall_pct = 0;
		test_random_walks(450);
		send_idle_pct = 65; recv_stall_pct = 0;
		test_random_walks(450);
		send_idle_pct = 0;  recv_stall_pct = 65;
		test_random_walks(450);
		send_idle_pct = 17; recv_stall_pct = 17;
		test_random_walks(450);
		drain_results();
		repeat (20) @(negedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#2_000_000_000;
		$display("Simulation FAILED");
		$finish;
	end
endmodule

// ----- sim.f -----
rtl/csg_pkg.sv
rtl/csg_datapath.sv
rtl/csg_ctrl.sv
rtl/combination_sequence_generator_unit.sv
rtl/csg_checker.sv
bench/tb.sv
